// ===== design/mth_pkg.sv =====
package mth_pkg;

  // Fixed field widths
  localparam int unsigned TAB_W     = 5;
  localparam int unsigned MASK_W    = 32;
  localparam int unsigned HIST_CNT_W = 6;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ACTIVATE  = 2'd0,
    CMD_REMOVE    = 2'd1,
    CMD_SELCHANGE = 2'd2,
    CMD_CLEAR     = 2'd3
  } cmd_e;

endpackage

// ===== design/mth_in_if.sv =====
interface mth_in_if;
  import mth_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic              tab_valid;
  logic [TAB_W-1:0]  tab_id;
  logic              restore_en;
  logic [MASK_W-1:0] present_mask;

  modport source (
    output valid, command, tab_valid, tab_id, restore_en, present_mask,
    input  ready
  );
  modport sink (
    input  valid, command, tab_valid, tab_id, restore_en, present_mask,
    output ready
  );
endinterface

// ===== design/mth_out_if.sv =====
interface mth_out_if;
  import mth_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  replacement_valid;
  logic [TAB_W-1:0]      replacement_tab;
  logic                  selected_valid;
  logic [TAB_W-1:0]      selected_tab;
  logic [HIST_CNT_W-1:0] history_count;

  modport source (
    output valid, replacement_valid, replacement_tab, selected_valid, selected_tab,
           history_count,
    input  ready
  );
  modport sink (
    input  valid, replacement_valid, replacement_tab, selected_valid, selected_tab,
           history_count,
    output ready
  );
endinterface

// ===== design/mru_tab_history_core.sv =====
// Most-recently-used tab list with a selected tab. The list lives in a single
// RAM with one write and one registered read port, and a small sequencer walks
// it one entry per cycle for every search and every shift. Per beat: clear or
// a null activate goes straight to the result; an activate searches, then
// shifts to the front; a remove searches and closes the gap, plus a restore
// search and a move to the front when the selected tab goes and restore is
// asked for; a selection change that retires a vanished tab can add a second
// search and shift for the new tab. The input is not ready while a command is
// being worked; the finished result sits in an output register, so the next
// command is taken while it waits to be collected.
module mru_tab_history_core #(
  parameter int unsigned NUM_TABS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mth_in_if.sink    in_i,
  mth_out_if.source out_o
);
  import mth_pkg::*;

  localparam int unsigned AW = $clog2(NUM_TABS);
  localparam int unsigned CW = $clog2(NUM_TABS + 1);
  localparam logic [CW-1:0] CntMax = CW'(NUM_TABS);
  localparam logic [CW-1:0] CntTop = CW'(NUM_TABS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_DEL  = 6'b000100,
    ST_POST = 6'b001000,
    ST_MOVE = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              cur_vld_q, cur_vld_d;
  logic [TAB_W-1:0]  cur_tab_q, cur_tab_d;
  logic [TAB_W-1:0]  tgt_q, tgt_d;
  logic              rest_scan_q, rest_scan_d;
  logic              mode_rem_q, mode_rem_d;
  logic              was_sel_q, was_sel_d;
  logic              restore_q, restore_d;
  logic              fallback_q, fallback_d;
  logic              new_vld_q, new_vld_d;
  logic [TAB_W-1:0]  new_id_q, new_id_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              found_q, found_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              pend_q, pend_d;
  logic              rep_vld_q, rep_vld_d;
  logic [TAB_W-1:0]  rep_tab_q, rep_tab_d;

  logic                  out_vld_q, out_vld_d;
  logic                  o_rep_vld_q, o_rep_vld_d;
  logic [TAB_W-1:0]      o_rep_tab_q, o_rep_tab_d;
  logic                  o_sel_vld_q, o_sel_vld_d;
  logic [TAB_W-1:0]      o_sel_tab_q, o_sel_tab_d;
  logic [HIST_CNT_W-1:0] o_cnt_q, o_cnt_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [TAB_W-1:0] ram_wdata, ram_rdata;

  logic          hit;
  logic          sel_retire;
  logic [CW-1:0] cnt_cap;

  mth_ram #(
    .DataWidth(TAB_W),
    .Depth    (NUM_TABS)
  ) u_list (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // shared compare: tab match or presence of the listed tab
  assign hit = pend_q && (rest_scan_q ? mask_q[ram_rdata] : (ram_rdata == tgt_q));

  // old selection gone on a selection change
  assign sel_retire = cur_vld_q && (!in_i.tab_valid || (cur_tab_q != in_i.tab_id)) &&
                      !in_i.present_mask[cur_tab_q];

  // list length with room made for a new front entry
  assign cnt_cap = (cnt_q >= CntMax) ? CntTop : cnt_q;

  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid             = out_vld_q;
  assign out_o.replacement_valid = o_rep_vld_q;
  assign out_o.replacement_tab   = o_rep_tab_q;
  assign out_o.selected_valid    = o_sel_vld_q;
  assign out_o.selected_tab      = o_sel_tab_q;
  assign out_o.history_count     = o_cnt_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_vld_d   = cur_vld_q;
    cur_tab_d   = cur_tab_q;
    tgt_d       = tgt_q;
    rest_scan_d = rest_scan_q;
    mode_rem_d  = mode_rem_q;
    was_sel_d   = was_sel_q;
    restore_d   = restore_q;
    fallback_d  = fallback_q;
    new_vld_d   = new_vld_q;
    new_id_d    = new_id_q;
    mask_d      = mask_q;
    found_d     = found_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    pend_d      = 1'b0;
    rep_vld_d   = rep_vld_q;
    rep_tab_d   = rep_tab_q;

    out_vld_d   = out_vld_q && !out_o.ready;
    o_rep_vld_d = o_rep_vld_q;
    o_rep_tab_d = o_rep_tab_q;
    o_sel_vld_d = o_sel_vld_q;
    o_sel_tab_d = o_sel_tab_q;
    o_cnt_d     = o_cnt_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mask_d      = in_i.present_mask;
          restore_d   = in_i.restore_en;
          new_vld_d   = in_i.tab_valid;
          new_id_d    = in_i.tab_id;
          rep_vld_d   = 1'b0;
          rep_tab_d   = '0;
          fallback_d  = 1'b0;
          was_sel_d   = 1'b0;
          rest_scan_d = 1'b0;
          found_d     = 1'b0;
          idx_d       = '0;
          tgt_d       = in_i.tab_id;
          mode_rem_d  = 1'b0;
          state_d     = ST_SCAN;
          unique case (cmd_e'(in_i.command))
            CMD_ACTIVATE: begin
              if (!in_i.tab_valid) begin
                cur_vld_d = 1'b0;
                cur_tab_d = '0;
                state_d   = ST_DONE;
              end
            end
            CMD_REMOVE: begin
              was_sel_d  = in_i.tab_valid && cur_vld_q && (cur_tab_q == in_i.tab_id);
              mode_rem_d = 1'b1;
              if (!in_i.tab_valid) begin
                state_d = ST_POST;
              end
            end
            CMD_SELCHANGE: begin
              if (sel_retire) begin
                tgt_d      = cur_tab_q;
                mode_rem_d = 1'b1;
                was_sel_d  = 1'b1;
                restore_d  = 1'b1;
                fallback_d = 1'b1;
              end else if (!in_i.tab_valid) begin
                cur_vld_d = 1'b0;
                cur_tab_d = '0;
                state_d   = ST_DONE;
              end
            end
            CMD_CLEAR: begin
              cnt_d     = '0;
              cur_vld_d = 1'b0;
              cur_tab_d = '0;
              state_d   = ST_DONE;
            end
            default: ;
          endcase
        end
      end

      // one entry read per cycle, compared the cycle after
      ST_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          if (rest_scan_q) begin
            tgt_d     = ram_rdata;
            rep_vld_d = 1'b1;
            rep_tab_d = ram_rdata;
            idx_d     = CW'(cmp_idx_q);
            state_d   = ST_MOVE;
          end else if (mode_rem_q) begin
            idx_d   = CW'(cmp_idx_q) + CW'(1);
            state_d = ST_DEL;
          end else begin
            idx_d   = CW'(cmp_idx_q);
            state_d = ST_MOVE;
          end
        end else if (idx_q < cnt_q) begin
          pend_d    = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else if (rest_scan_q) begin
          // no present tab left
          if (fallback_q && new_vld_q) begin
            rest_scan_d = 1'b0;
            mode_rem_d  = 1'b0;
            tgt_d       = new_id_q;
            found_d     = 1'b0;
            idx_d       = '0;
          end else begin
            state_d = ST_DONE;
          end
        end else if (mode_rem_q) begin
          state_d = ST_POST;
        end else begin
          found_d = 1'b0;
          idx_d   = cnt_cap;
          state_d = ST_MOVE;
        end
      end

      // close the gap: entry i+1 moves to i
      ST_DEL: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q < cnt_q) begin
          pend_d    = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_POST;
        end
      end

      // selected tab gone: drop selection, maybe look for a replacement
      ST_POST: begin
        state_d = ST_DONE;
        if (was_sel_q) begin
          cur_vld_d = 1'b0;
          cur_tab_d = '0;
          if (restore_q) begin
            rest_scan_d = 1'b1;
            idx_d       = '0;
            state_d     = ST_SCAN;
          end
        end
      end

      // shift entries down by one from the end, then write the front
      ST_MOVE: begin
        ram_raddr = idx_q[AW-1:0] - AW'(1);
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_q + AW'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_q != '0) begin
          pend_d    = 1'b1;
          cmp_idx_d = idx_q[AW-1:0] - AW'(1);
          idx_d     = idx_q - CW'(1);
        end else if (!pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = tgt_q;
          if (!found_q) begin
            cnt_d = cnt_cap + CW'(1);
          end
          cur_vld_d = 1'b1;
          cur_tab_d = tgt_q;
          state_d   = ST_DONE;
        end
      end

      // hand the result beat to the output register
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d   = 1'b1;
          o_rep_vld_d = rep_vld_q;
          o_rep_tab_d = rep_tab_q;
          o_sel_vld_d = cur_vld_q;
          o_sel_tab_d = cur_tab_q;
          o_cnt_d     = HIST_CNT_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cur_vld_q <= 1'b0;
      cur_tab_q <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_vld_q <= cur_vld_d;
      cur_tab_q <= cur_tab_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    rest_scan_q <= rest_scan_d;
    mode_rem_q  <= mode_rem_d;
    was_sel_q   <= was_sel_d;
    restore_q   <= restore_d;
    fallback_q  <= fallback_d;
    new_vld_q   <= new_vld_d;
    new_id_q    <= new_id_d;
    mask_q      <= mask_d;
    found_q     <= found_d;
    idx_q       <= idx_d;
    cmp_idx_q   <= cmp_idx_d;
    rep_vld_q   <= rep_vld_d;
    rep_tab_q   <= rep_tab_d;
    o_rep_vld_q <= o_rep_vld_d;
    o_rep_tab_q <= o_rep_tab_d;
    o_sel_vld_q <= o_sel_vld_d;
    o_sel_tab_q <= o_sel_tab_d;
    o_cnt_q     <= o_cnt_d;
  end

endmodule

// ===== design/mth_ram.sv =====
module mth_ram #(
  parameter int unsigned DataWidth = 5,
  parameter int unsigned Depth     = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataWidth-1:0]     wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataWidth-1:0]     rdata_o
);

  logic [DataWidth-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
